@@ src/tshash_pkg.sv @@
package tshash_pkg;

    localparam int HASH_W = 64;
    localparam int HALF_W = 32;

    localparam logic [HALF_W-1:0] SEED_DEF32   = 32'h7FED7FED;
    localparam logic [HASH_W-1:0] SEED_DEF64   = 64'h7FED7FED7FED7FED;
    localparam logic [HALF_W-1:0] ADJ_INIT32   = 32'hEEEEEEEE;
    localparam logic [HASH_W-1:0] ADJ_INIT64   = 64'hEEEEEEEEEEEEEEEE;
    localparam logic [HASH_W-1:0] ADJ_BIAS     = 64'd3;
    localparam int               ADJ_SHIFT    = 5;

    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_CASE    = 8'h20;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_BSLASH  = 8'h5C;

    localparam logic [HALF_W-1:0] TAB32 [16] = '{
        32'h486E26EE, 32'hDCAA16B3, 32'hE1918EEF, 32'h202DAFDB,
        32'h341C7DC7, 32'h1C365303, 32'h40EF2D37, 32'h65FD5E49,
        32'hD6057177, 32'h904ECE93, 32'h1C38024F, 32'h98FD323B,
        32'hE3061AE7, 32'hA39B0FA1, 32'h9797F25F, 32'hE4444563
    };

    localparam logic [HASH_W-1:0] TAB64 [16] = '{
        64'h486E26EEDCAA16B3, 64'hE1918EEF202DAFDB,
        64'h341C7DC71C365303, 64'h40EF2D3765FD5E49,
        64'hD6057177904ECE93, 64'h1C38024F98FD323B,
        64'hE3061AE7A39B0FA1, 64'h9797F25FE4444563,
        64'hCD2EC20C8DC1B898, 64'h31759633799A306D,
        64'h8C2063852E6E9627, 64'h79237D9973922C66,
        64'h8728628D28628824, 64'h8F1F7E9625887795,
        64'h296E3281389C0D60, 64'h6F4893CA61636542
    };

    typedef enum logic [1:0] {
        REG_CASE_SENSITIVE = 2'd0,
        REG_WIDE_MODE      = 2'd1,
        REG_WIDE_SUBTRACTS = 2'd2,
        REG_SEED_VALUE     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic case_sensitive;
        logic wide_mode;
        logic wide_subtracts;
    } mode_t;

endpackage

@@ src/tshash_if.sv @@
interface tshash_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       has_byte;
    logic       last_byte;

    modport source (output valid, output char_byte, output has_byte, output last_byte,
                    input ready);
    modport sink   (input valid, input char_byte, input has_byte, input last_byte,
                    output ready);
endinterface

interface tshash_hash_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_out;

    modport source (output valid, output hash_out, input ready);
    modport sink   (input valid, input hash_out, output ready);
endinterface

@@ src/table_string_hash_32_64.sv @@
// Channel     Role   Payload                          Beat
// char_chan   sink   char_byte[8] has_byte last_byte  one string byte or end mark
// hash_chan   source hash_out[64]                     one hash per string
// cfg port    write  cfg_we cfg_index[2] cfg_data[64] one register write
//
// One byte per cycle sustained unless the hash beat stalls; input beat is
// registered, then the hash/adjust update (add, xor, 33x add chain) writes
// state and, on a last beat, the result register that drives the hash beat.
// rst_n clears config, state and valid flags; the next beat starts a string.
// A stalled hash beat stops the update stage; input still fills the empty slot.
module table_string_hash_32_64
(
    input  logic                clk,
    input  logic                rst_n,
    tshash_byte_if.sink         char_chan,
    tshash_hash_if.source       hash_chan,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data
);

    tshash_pkg::mode_t mode;

    logic        case_sensitive_reg;
    logic        wide_mode_reg;
    logic        wide_subtracts_reg;
    logic [63:0] seed_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_char_reg;
    logic        s1_has_reg;
    logic        s1_last_reg;

    logic [63:0] hash_reg;
    logic [63:0] adj_reg;
    logic        in_string_reg;

    logic        out_valid_reg;
    logic [63:0] out_hash_reg;

    logic [63:0] hash_next;
    logic [63:0] adj_next;
    logic [63:0] hash_final;

    logic        s1_go;
    logic        in_fire;

    assign mode = '{case_sensitive: case_sensitive_reg,
                    wide_mode:      wide_mode_reg,
                    wide_subtracts: wide_subtracts_reg};

    assign s1_go          = s1_valid_reg && (!out_valid_reg || hash_chan.ready);
    assign char_chan.ready = !s1_valid_reg || s1_go;
    assign in_fire        = char_chan.valid && char_chan.ready;

    assign hash_chan.valid    = out_valid_reg;
    assign hash_chan.hash_out = out_hash_reg;

    tshash_mix u_mix
    (
        .mode       (mode),
        .seed       (seed_reg),
        .start      (!in_string_reg),
        .hash_cur   (hash_reg),
        .adj_cur    (adj_reg),
        .char_byte  (s1_char_reg),
        .has_byte   (s1_has_reg),
        .hash_next  (hash_next),
        .adj_next   (adj_next),
        .hash_final (hash_final)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            case_sensitive_reg <= 1'b0;
            wide_mode_reg      <= 1'b0;
            wide_subtracts_reg <= 1'b0;
            seed_reg           <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tshash_pkg::REG_CASE_SENSITIVE: case_sensitive_reg <= cfg_data[0];
                tshash_pkg::REG_WIDE_MODE:      wide_mode_reg      <= cfg_data[0];
                tshash_pkg::REG_WIDE_SUBTRACTS: wide_subtracts_reg <= cfg_data[0];
                tshash_pkg::REG_SEED_VALUE:     seed_reg           <= cfg_data;
                default:                        seed_reg           <= seed_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            hash_reg      <= '0;
            adj_reg       <= '0;
            in_string_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go)
            begin
                hash_reg      <= hash_next;
                adj_reg       <= adj_next;
                in_string_reg <= !s1_last_reg;
            end

            if (s1_go && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (hash_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_char_reg <= char_chan.char_byte;
            s1_has_reg  <= char_chan.has_byte;
            s1_last_reg <= char_chan.last_byte;
        end
        if (s1_go && s1_last_reg)
        begin
            out_hash_reg <= hash_final;
        end
    end

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_last_reg |=> hash_chan.valid)
        else $error("last beat did not produce a hash beat");

    a_last_ends_string: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_last_reg |=> !in_string_reg)
        else $error("string not closed after last beat");

    a_hash_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        hash_chan.valid |-> hash_chan.hash_out != 64'd0)
        else $error("zero hash emitted");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> char_chan.ready)
        else $error("input stalled with empty update stage");

endmodule

@@ src/tshash_mix.sv @@
module tshash_mix
(
    input  tshash_pkg::mode_t   mode,
    input  logic [63:0]         seed,
    input  logic                start,
    input  logic [63:0]         hash_cur,
    input  logic [63:0]         adj_cur,
    input  logic [7:0]          char_byte,
    input  logic                has_byte,
    output logic [63:0]         hash_next,
    output logic [63:0]         adj_next,
    output logic [63:0]         hash_final
);

    logic [7:0]  c;
    logic [63:0] h_start;
    logic [63:0] a_start;
    logic [63:0] h_op;
    logic [63:0] a_op;
    logic [63:0] t_hi;
    logic [63:0] t_lo;
    logic [31:0] t32;
    logic [63:0] mix;
    logic [63:0] h_new;
    logic [63:0] a_new;
    logic [63:0] h_masked;

    // case folding and slash-to-backslash mapping
    always_comb
    begin
        c = char_byte;
        if (!mode.case_sensitive)
        begin
            if (c inside {[tshash_pkg::CHAR_LOWER_A:tshash_pkg::CHAR_LOWER_Z]})
            begin
                c = c - tshash_pkg::CHAR_CASE;
            end
            if (c == tshash_pkg::CHAR_SLASH)
            begin
                c = tshash_pkg::CHAR_BSLASH;
            end
        end
    end

    // string start loads seed or defaults
    always_comb
    begin
        if (!start)
        begin
            h_start = hash_cur;
            a_start = adj_cur;
        end
        else if (mode.wide_mode)
        begin
            h_start = (seed != '0) ? seed : tshash_pkg::SEED_DEF64;
            a_start = tshash_pkg::ADJ_INIT64;
        end
        else
        begin
            h_start = {32'd0, (seed[31:0] != '0) ? seed[31:0] : tshash_pkg::SEED_DEF32};
            a_start = {32'd0, tshash_pkg::ADJ_INIT32};
        end
    end

    always_comb
    begin
        h_op = mode.wide_mode ? h_start : {32'd0, h_start[31:0]};
        a_op = mode.wide_mode ? a_start : {32'd0, a_start[31:0]};
        t_hi = tshash_pkg::TAB64[c[7:4]];
        t_lo = tshash_pkg::TAB64[c[3:0]];
        t32  = tshash_pkg::TAB32[c[7:4]] - tshash_pkg::TAB32[c[3:0]];
        if (!mode.wide_mode)
        begin
            mix = {32'd0, t32};
        end
        else if (mode.wide_subtracts)
        begin
            mix = t_hi - t_lo;
        end
        else
        begin
            mix = t_hi + t_lo;
        end
        h_new = mix ^ (a_op + h_op);
        a_new = (a_op << tshash_pkg::ADJ_SHIFT) + a_op + h_new + {56'd0, c}
                + tshash_pkg::ADJ_BIAS;
        if (!mode.wide_mode)
        begin
            h_new = {32'd0, h_new[31:0]};
            a_new = {32'd0, a_new[31:0]};
        end
    end

    assign hash_next = has_byte ? h_new : h_start;
    assign adj_next  = has_byte ? a_new : a_start;
    assign h_masked  = mode.wide_mode ? hash_next : {32'd0, hash_next[31:0]};
    assign hash_final = (h_masked == '0) ? 64'd1 : h_masked;

endmodule
